// File: hdl/mme_pkg.sv
// mme_pkg: shared types and codes of the matrix multiply engine
// used by mme_controller, mme_datapath and matrix_multiply_engine
// no dependencies
package mme_pkg;

    // request command codes
    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_COLS_A = 2'd1;
    localparam logic [1:0] REG_ROWS_B = 2'd2;
    localparam logic [1:0] REG_COLS_B = 2'd3;

    // fixed field widths
    localparam int COORD_W  = 3;
    localparam int VALUE_W  = 16;
    localparam int RESULT_W = 32;
    localparam int CFG_W    = 4;

    // one multiply-accumulate step issued by the controller
    typedef struct packed {
        logic               valid;
        logic               first;    // first term of a result element
        logic               lastk;    // final term of a result element
        logic               err;      // shape error result
        logic               last;     // final result of the compute
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } step_t;

    // controller to datapath command group
    typedef struct packed {
        logic  load_a;
        logic  load_b;
        step_t step;
    } cmd_t;

endpackage

// File: hdl/mme_controller.sv
// mme_controller: configuration registers, request decode and the
// sequencer that walks result elements and their inner terms
// depends on mme_pkg
module mme_controller import mme_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_index,
    input  logic [CFG_W-1:0]                    cfg_wr_data,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [1:0]                          req_command,
    input  logic [COORD_W-1:0]                  req_row,
    input  logic [COORD_W-1:0]                  req_column,
    input  logic                                busy,
    output cmd_t                                cmd,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  wr_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  rd_addr_a,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  rd_addr_b
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_ISSUE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CFG_W-1:0] rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IDX_W-1:0] lim_i_reg, lim_i_next, lim_j_reg, lim_j_next;
    logic [IDX_W-1:0] lim_k_reg, lim_k_next;
    logic             vec_reg, vec_next, as_row_reg, as_row_next;
    logic             err_reg, err_next;

    logic             accept;
    logic             in_range;
    logic [IDX_W-1:0] lra, lca, lrb, lcb, vlen, vmin;
    logic             vec_mode, shape_bad;
    logic             k_done, elem_last;

    // size register to highest index, out of range values clamped
    function automatic logic [IDX_W-1:0] dim_limit(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return '0;
        end
        if (v > CFG_W'(MAX_DIM)) begin
            return IDX_W'(MAX_DIM - 1);
        end
        return IDX_W'(v - CFG_W'(1));
    endfunction

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg <= CFG_W'(1);
            cols_a_reg <= CFG_W'(1);
            rows_b_reg <= CFG_W'(1);
            cols_b_reg <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROWS_A: rows_a_reg <= cfg_wr_data;
                REG_COLS_A: cols_a_reg <= cfg_wr_data;
                REG_ROWS_B: rows_b_reg <= cfg_wr_data;
                REG_COLS_B: cols_b_reg <= cfg_wr_data;
                default:    rows_a_reg <= rows_a_reg;
            endcase
        end
    end

    // shape decode
    always_comb begin
        lra       = dim_limit(rows_a_reg);
        lca       = dim_limit(cols_a_reg);
        lrb       = dim_limit(rows_b_reg);
        lcb       = dim_limit(cols_b_reg);
        vec_mode  = (lrb == '0) || (lcb == '0);
        vlen      = (lrb == '0) ? lcb : lrb;
        vmin      = (lca < vlen) ? lca : vlen;
        shape_bad = !vec_mode && (lrb != lca);
    end

    // request decode and load write address
    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign in_range  = ({1'b0, req_row} < (COORD_W+1)'(MAX_DIM)) &&
                       ({1'b0, req_column} < (COORD_W+1)'(MAX_DIM));
    assign wr_addr   = ADDR_W'(req_row) * ADDR_W'(MAX_DIM) + ADDR_W'(req_column);

    // step status
    assign k_done    = (k_reg == lim_k_reg);
    assign elem_last = (i_reg == lim_i_reg) && (j_reg == lim_j_reg);

    // sequencer
    always_comb begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        lim_i_next  = lim_i_reg;
        lim_j_next  = lim_j_reg;
        lim_k_next  = lim_k_reg;
        vec_next    = vec_reg;
        as_row_next = as_row_reg;
        err_next    = err_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && req_command == CMD_COMPUTE) begin
                    state_next  = ST_WAIT;
                    i_next      = '0;
                    j_next      = '0;
                    k_next      = '0;
                    vec_next    = vec_mode;
                    as_row_next = (lrb == '0);
                    err_next    = shape_bad;
                    lim_i_next  = shape_bad ? '0 : lra;
                    lim_j_next  = (shape_bad || vec_mode) ? '0 : lcb;
                    lim_k_next  = shape_bad ? '0 : (vec_mode ? vmin : lca);
                end
            end
            ST_WAIT: begin
                if (!busy) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (k_done) begin
                    k_next = '0;
                    if (elem_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_WAIT;
                        if (j_reg == lim_j_reg) begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end else begin
                            j_next = j_reg + IDX_W'(1);
                        end
                    end
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        lim_i_reg  <= lim_i_next;
        lim_j_reg  <= lim_j_next;
        lim_k_reg  <= lim_k_next;
        vec_reg    <= vec_next;
        as_row_reg <= as_row_next;
        err_reg    <= err_next;
    end

    // read addresses of the current term
    always_comb begin
        rd_addr_a = ADDR_W'(i_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(k_reg);
        if (vec_reg && as_row_reg) begin
            rd_addr_b = ADDR_W'(k_reg);
        end else if (vec_reg) begin
            rd_addr_b = ADDR_W'(k_reg) * ADDR_W'(MAX_DIM);
        end else begin
            rd_addr_b = ADDR_W'(k_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(j_reg);
        end
    end

    // command group
    always_comb begin
        cmd.load_a     = accept && (req_command == CMD_LOAD_A) && in_range;
        cmd.load_b     = accept && (req_command == CMD_LOAD_B) && in_range;
        cmd.step.valid = (state_reg == ST_ISSUE);
        cmd.step.first = (k_reg == '0);
        cmd.step.lastk = k_done;
        cmd.step.err   = err_reg;
        cmd.step.last  = elem_last;
        cmd.step.row   = vec_reg ? '0 : COORD_W'(i_reg);
        cmd.step.col   = vec_reg ? COORD_W'(i_reg) : COORD_W'(j_reg);
    end

endmodule

// File: hdl/mme_datapath.sv
// mme_datapath: element stores, multiplier, accumulator, saturation
// and the result register
// depends on mme_pkg
module mme_datapath import mme_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cmd_t                                cmd,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  wr_addr,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  rd_addr_a,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  rd_addr_b,
    input  logic signed [VALUE_W-1:0]           wr_data,
    output logic                                busy,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [COORD_W-1:0]                  out_row,
    output logic [COORD_W-1:0]                  out_col,
    output logic signed [RESULT_W-1:0]          out_result,
    output logic                                out_err,
    output logic                                out_last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int ACC_W  = 2 * VALUE_W + CNT_W;
    localparam int PROD_W = 2 * VALUE_W;

    logic signed [VALUE_W-1:0]  mem_a [DEPTH];
    logic signed [VALUE_W-1:0]  mem_b [DEPTH];
    logic signed [VALUE_W-1:0]  a_reg, b_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next, prod_ext;
    logic signed [RESULT_W-1:0] sat_value;
    logic [ACC_W-RESULT_W:0]    acc_top;
    step_t                      s1_reg, s2_reg;
    logic                       out_valid_reg;
    logic [COORD_W-1:0]         out_row_reg, out_col_reg;
    logic signed [RESULT_W-1:0] out_result_reg;
    logic                       out_err_reg, out_last_reg;

    // element stores, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (cmd.load_a) begin
            mem_a[wr_addr] <= wr_data;
        end
        a_reg <= mem_a[rd_addr_a];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_b) begin
            mem_b[wr_addr] <= wr_data;
        end
        b_reg <= mem_b[rd_addr_b];
    end

    // step tags follow the data through the pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
            s2_reg <= '0;
        end else begin
            s1_reg <= cmd.step;
            s2_reg <= s1_reg;
        end
    end

    // exact product of two q8.8 terms
    always_ff @(posedge aclk) begin
        prod_reg <= a_reg * b_reg;
    end

    // accumulate terms of one result element
    assign prod_ext = ACC_W'(prod_reg);
    assign acc_next = s2_reg.first ? prod_ext : acc_reg + prod_ext;

    always_ff @(posedge aclk) begin
        if (s2_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    // saturate the wide sum to 32 bits
    assign acc_top = acc_next[ACC_W-1:RESULT_W-1];
    always_comb begin
        if ((&acc_top) || !(|acc_top)) begin
            sat_value = acc_next[RESULT_W-1:0];
        end else if (acc_next[ACC_W-1]) begin
            sat_value = {1'b1, {(RESULT_W-1){1'b0}}};
        end else begin
            sat_value = {1'b0, {(RESULT_W-1){1'b1}}};
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s2_reg.valid && s2_reg.lastk) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_reg.valid && s2_reg.lastk) begin
            out_row_reg    <= s2_reg.row;
            out_col_reg    <= s2_reg.col;
            out_result_reg <= s2_reg.err ? '0 : sat_value;
            out_err_reg    <= s2_reg.err;
            out_last_reg   <= s2_reg.last;
        end
    end

    assign busy       = s1_reg.valid || s2_reg.valid || out_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign out_result = out_result_reg;
    assign out_err    = out_err_reg;
    assign out_last   = out_last_reg;

endmodule

// File: hdl/matrix_multiply_engine.sv
// matrix_multiply_engine: top level, stream ports and configuration port
// depends on mme_pkg, mme_controller, mme_datapath
//
// Input stream: each request loads one element of A or B (tuser command
// 0 or 1) or starts a compute (command 2). Loads are taken one per cycle
// while no compute is being sequenced; a load outside the store or an
// unknown command is dropped. Sizes come from the four configuration
// registers, which the user must write only while the block is idle;
// the block itself does not enforce this. A compute walks the result in
// row-major order. Each result element passes the wait state, then one
// inner term per cycle (len = cols_a, or the shorter of cols_a and the
// vector length in vector mode) goes through the single multiplier and
// accumulator, then through the store read, product and result
// registers. The next element starts only once the result register has
// been taken, so a stalled receiver simply holds the engine; nothing is lost.
// Output stream: tlast marks the final result of a compute, tuser carries
// the shape error flag. Reset (aresetn low, synchronous) empties the
// pipe and the result register and sets all sizes to 1; element stores
// keep no defined contents until written.
module matrix_multiply_engine import mme_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wr_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row[2:0], column[5:3], value[21:6], zero pad
    input  logic [1:0]  s_tuser,   // command[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_row[2:0], out_column[5:3], result[37:6], pad
    output logic        m_tuser,   // shape_error[0]
    output logic        m_tlast
);

    localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);

    cmd_t                       cmd;
    logic                       busy;
    logic [ADDR_W-1:0]          wr_addr, rd_addr_a, rd_addr_b;
    logic [COORD_W-1:0]         out_row, out_col;
    logic signed [RESULT_W-1:0] out_result;

    mme_controller #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_command (s_tuser),
        .req_row     (s_tdata[2:0]),
        .req_column  (s_tdata[5:3]),
        .busy        (busy),
        .cmd         (cmd),
        .wr_addr     (wr_addr),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b)
    );

    mme_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .wr_addr    (wr_addr),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .wr_data    (s_tdata[21:6]),
        .busy       (busy),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_result (out_result),
        .out_err    (m_tuser),
        .out_last   (m_tlast)
    );

    // pack result fields
    assign m_tdata = {2'b00, out_result, out_col, out_row};

endmodule

// File: test/tb.sv
// tb: self-checking bench for matrix_multiply_engine, loads, computes and checks results
// depends on mme_pkg and the matrix_multiply_engine rtl, nothing else
// predicts each compute from its own copy of both element stores and the size registers
module tb import mme_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM = 8;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_GUARD = 40000;
    localparam longint SAT_MAX = 64'sd2147483647;
    localparam longint SAT_MIN = -64'sd2147483648;

    // one result element as seen on the result stream
    typedef struct {
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic [RESULT_W-1:0] value;
        logic                err;
        logic                last;
    } element_t;

    // element stores, size registers and the queue of predicted elements
    class product_scoreboard;
        logic signed [VALUE_W-1:0] elem_a [MAX_DIM*MAX_DIM];
        logic signed [VALUE_W-1:0] elem_b [MAX_DIM*MAX_DIM];
        bit                        loaded_a [MAX_DIM*MAX_DIM];
        bit                        loaded_b [MAX_DIM*MAX_DIM];
        logic [CFG_W-1:0]          size_reg [4];
        element_t                  expected_elements [$];
        int                        errors;

        function new();
            foreach (size_reg[i]) size_reg[i] = 4'd1;
            foreach (loaded_a[i]) begin
                loaded_a[i] = 1'b0;
                loaded_b[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function void set_size(int idx, logic [CFG_W-1:0] v);
            size_reg[idx] = v;
        endfunction

        // size as the engine uses it: 0 counts as 1, above MAX_DIM as MAX_DIM
        function int dim(int idx);
            int v;
            v = size_reg[idx];
            if (v < 1) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return v;
        endfunction

        function logic [RESULT_W-1:0] saturate(longint s);
            if (s > SAT_MAX) return 32'h7fff_ffff;
            if (s < SAT_MIN) return 32'h8000_0000;
            return s[RESULT_W-1:0];
        endfunction

        function void push(int r, int c, logic [RESULT_W-1:0] v, bit err, bit last);
            element_t e;
            e.row = 3'(r);
            e.col = 3'(c);
            e.value = v;
            e.err = err;
            e.last = last;
            expected_elements.push_back(e);
        endfunction

        // expected elements of one compute request
        function void predict_product();
            int ra, ca, rb, cb, len;
            bit as_row;
            longint acc;
            logic signed [VALUE_W-1:0] b;
            ra = dim(REG_ROWS_A);
            ca = dim(REG_COLS_A);
            rb = dim(REG_ROWS_B);
            cb = dim(REG_COLS_B);
            if (rb == 1 || cb == 1) begin
                // vector mode, b is row 0 or column 0 of B, short side wins
                as_row = (rb == 1);
                len = as_row ? cb : rb;
                if (ca < len) len = ca;
                for (int i = 0; i < ra; i++) begin
                    acc = 0;
                    for (int k = 0; k < len; k++) begin
                        b = as_row ? elem_b[k] : elem_b[k*MAX_DIM];
                        acc += longint'(elem_a[i*MAX_DIM+k]) * longint'(b);
                    end
                    push(0, i, saturate(acc), 1'b0, i == ra - 1);
                end
            end else if (rb != ca) begin
                // shape error, one flagged element
                push(0, 0, '0, 1'b1, 1'b1);
            end else begin
                for (int i = 0; i < ra; i++) begin
                    for (int j = 0; j < cb; j++) begin
                        acc = 0;
                        for (int k = 0; k < ca; k++)
                            acc += longint'(elem_a[i*MAX_DIM+k])
                                 * longint'(elem_b[k*MAX_DIM+j]);
                        push(i, j, saturate(acc), 1'b0, i == ra - 1 && j == cb - 1);
                    end
                end
            end
        endfunction

        // an accepted request updates a store or starts a compute
        function void note_request(logic [1:0] cmd, logic [COORD_W-1:0] row,
                                   logic [COORD_W-1:0] col, logic [VALUE_W-1:0] value);
            case (cmd)
                CMD_LOAD_A: begin
                    elem_a[row*MAX_DIM+col] = value;
                    loaded_a[row*MAX_DIM+col] = 1'b1;
                end
                CMD_LOAD_B: begin
                    elem_b[row*MAX_DIM+col] = value;
                    loaded_b[row*MAX_DIM+col] = 1'b1;
                end
                CMD_COMPUTE: predict_product();
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(element_t got);
            element_t exp_e;
            if (expected_elements.size() == 0) begin
                report($sformatf("unexpected element row %0d col %0d value %h",
                                 got.row, got.col, got.value));
                return;
            end
            exp_e = expected_elements.pop_front();
            if (got.row !== exp_e.row || got.col !== exp_e.col ||
                got.value !== exp_e.value || got.err !== exp_e.err ||
                got.last !== exp_e.last)
                report($sformatf({"got r%0d c%0d %h err %b last %b, ",
                                  "expected r%0d c%0d %h err %b last %b"},
                                 got.row, got.col, got.value, got.err, got.last,
                                 exp_e.row, exp_e.col, exp_e.value, exp_e.err, exp_e.last));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // row[2:0], column[5:3], value[21:6], zero pad
    logic [1:0]  s_tuser = '0;   // command[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // out_row[2:0], out_column[5:3], result[37:6], pad
    logic        m_tuser;        // shape_error[0]
    logic        m_tlast;

    product_scoreboard sb;
    bit steady = 1'b0;
    bit hold_req = 1'b0;
    int items_sent = 0;

    matrix_multiply_engine #(.MAX_DIM(MAX_DIM)) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // element value, extremes and small values mixed in
    function automatic logic [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8) return 16'h8000;
        if (sel < 16) return 16'h7fff;
        if (sel < 20) return 16'h0000;
        if (sel < 60) return 16'($urandom_range(0, 1023)) - 16'd512;
        return 16'($urandom);
    endfunction

    // size register value, mostly small, now and then out of range
    function automatic logic [CFG_W-1:0] pick_dim();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5) return $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
        if (sel < 80) return 4'($urandom_range(1, 4));
        return 4'($urandom_range(5, 8));
    endfunction

    // offer one request, with random idle cycles in front
    task automatic send_item(logic [1:0] cmd, logic [COORD_W-1:0] row,
                             logic [COORD_W-1:0] col, logic [VALUE_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, value, col, row};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, row, col, value);
        if (cmd != CMD_UNKNOWN) items_sent++;
    endtask

    // write all four size registers back to back
    task automatic set_sizes(logic [CFG_W-1:0] ra, logic [CFG_W-1:0] ca,
                             logic [CFG_W-1:0] rb, logic [CFG_W-1:0] cb);
        logic [CFG_W-1:0] vals [4];
        vals[REG_ROWS_A] = ra;
        vals[REG_COLS_A] = ca;
        vals[REG_ROWS_B] = rb;
        vals[REG_COLS_B] = cb;
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 2'(i);
            cfg_wr_data <= vals[i];
            sb.set_size(i, vals[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic ensure_loaded(bit is_b, int r, int c);
        bit done;
        done = is_b ? sb.loaded_b[r*MAX_DIM+c] : sb.loaded_a[r*MAX_DIM+c];
        if (!done) send_item(is_b ? CMD_LOAD_B : CMD_LOAD_A, 3'(r), 3'(c), pick_value());
    endtask

    // load every element the next compute reads that was never written, then compute
    task automatic run_compute();
        int ra, ca, rb, cb, len;
        ra = sb.dim(REG_ROWS_A);
        ca = sb.dim(REG_COLS_A);
        rb = sb.dim(REG_ROWS_B);
        cb = sb.dim(REG_COLS_B);
        if (rb == 1 || cb == 1) begin
            len = (rb == 1) ? cb : rb;
            if (ca < len) len = ca;
            for (int i = 0; i < ra; i++)
                for (int k = 0; k < len; k++) ensure_loaded(1'b0, i, k);
            for (int k = 0; k < len; k++) begin
                if (rb == 1) ensure_loaded(1'b1, 0, k);
                else ensure_loaded(1'b1, k, 0);
            end
        end else if (rb == ca) begin
            for (int i = 0; i < ra; i++)
                for (int k = 0; k < ca; k++) ensure_loaded(1'b0, i, k);
            for (int k = 0; k < ca; k++)
                for (int j = 0; j < cb; j++) ensure_loaded(1'b1, k, j);
        end
        send_item(CMD_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
    endtask

    // stop offering, wait for every predicted element, then let the engine settle
    task automatic wait_idle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sb.expected_elements.size() > 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        if (sb.expected_elements.size() > 0) begin
            sb.report($sformatf("%0d elements never arrived", sb.expected_elements.size()));
            sb.expected_elements.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side ready, random idling and one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 38);
        end
    end

    // result monitor
    always @(posedge aclk) begin : result_monitor
        element_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.row = m_tdata[2:0];
            got.col = m_tdata[5:3];
            got.value = m_tdata[37:6];
            got.err = m_tuser;
            got.last = m_tlast;
            sb.check_result(got);
        end
    end

    // stimulus
    initial begin
        int phase, kind, n_ops, n_loads;
        logic [CFG_W-1:0] ra, ca, rb, cb;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // saturation both ways, column vector of length 4
        set_sizes(4'd2, 4'd4, 4'd4, 4'd1);
        for (int k = 0; k < 4; k++) begin
            send_item(CMD_LOAD_A, 3'd0, 3'(k), 16'h8000);
            send_item(CMD_LOAD_A, 3'd1, 3'(k), 16'h7fff);
            send_item(CMD_LOAD_B, 3'(k), 3'd0, 16'h8000);
        end
        run_compute();
        send_item(CMD_UNKNOWN, 3'd7, 3'd7, 16'hffff);
        wait_idle();

        // inner sizes disagree in matrix mode
        set_sizes(4'd2, 4'd4, 4'd3, 4'd2);
        run_compute();
        wait_idle();

        // out of range sizes, row vector longer than the inner size
        set_sizes(4'd15, 4'd0, 4'd0, 4'd15);
        run_compute();
        wait_idle();

        // random phases
        phase = 0;
        while (items_sent < 210) begin
            kind = $urandom_range(0, 99);
            ra = pick_dim();
            ca = pick_dim();
            if (kind < 50) begin
                rb = ca;
                cb = pick_dim();
            end else if (kind < 65) begin
                rb = pick_dim();
                cb = pick_dim();
            end else if ($urandom_range(0, 1)) begin
                rb = 4'd1;
                cb = pick_dim();
            end else begin
                rb = pick_dim();
                cb = 4'd1;
            end
            n_ops = $urandom_range(1, 3);
            if (phase == 1) begin
                // many results while the receiver holds off
                ra = 4'd4;
                ca = 4'd2;
                rb = 4'd2;
                cb = 4'd4;
                n_ops = 2;
            end
            steady = (phase == 2);
            set_sizes(ra, ca, rb, cb);
            for (int op = 0; op < n_ops; op++) begin
                n_loads = $urandom_range(0, 12);
                for (int n = 0; n < n_loads; n++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(CMD_UNKNOWN, 3'($urandom), 3'($urandom), 16'($urandom));
                    else
                        send_item($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
                                  3'($urandom), 3'($urandom), pick_value());
                end
                if (phase == 1 && op == 0) hold_req = 1'b1;
                run_compute();
            end
            wait_idle();
            steady = 1'b0;
            phase++;
        end

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial begin
        #6_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: matrix_multiply_engine.f
hdl/mme_pkg.sv
hdl/mme_controller.sv
hdl/mme_datapath.sv
hdl/matrix_multiply_engine.sv
test/tb.sv
